// ----- hdl/bdrs_pkg.sv -----
`default_nettype none

package bdrs_pkg;

  // Field widths of the input and result beats.
  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;

  // The query walk index can run one past the last index of a range.
  localparam int WALK_W = IDX_W + 1;

  // Default store geometry.
  localparam int DEPTH_DEF      = 1024;
  localparam int BLOCK_SIZE_DEF = 32;

  // Operation codes.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture an accepted input beat
    logic clr_step;  // write zero at the clear pointer and advance it
    logic wr_upd;    // write the element and the adjusted block sum
    logic q_step;    // issue one read of the query walk and advance
  } bdrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // clear pointer is at the last entry
    logic is_query;  // operation of the beat presented on the input
    logic more;      // the query walk has not passed the last index yet
  } bdrs_sts_t;

endpackage

`default_nettype wire

// ----- hdl/bdrs_ctrl.sv -----
`default_nettype none

module bdrs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  output logic                    out_valid,
  input  wire bdrs_pkg::bdrs_sts_t sts,
  output bdrs_pkg::bdrs_cmd_t     cmd
);
  import bdrs_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_WR_RD  = 6'b000100,
    ST_WR_UPD = 6'b001000,
    ST_Q_RUN  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = sts.is_query ? ST_Q_RUN : ST_WR_RD;
        end
      end
      ST_WR_RD:  state_nxt = ST_WR_UPD;
      ST_WR_UPD: state_nxt = ST_IDLE;
      ST_Q_RUN: begin
        if (!sts.more) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd.load     = (state_r == ST_IDLE) && start;
    cmd.clr_step = (state_r == ST_CLEAR);
    cmd.wr_upd   = (state_r == ST_WR_UPD);
    cmd.q_step   = (state_r == ST_Q_RUN);
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

endmodule

`default_nettype wire

// ----- hdl/bdrs_dp.sv -----
`default_nettype none

module bdrs_dp #(
  parameter int DEPTH      = bdrs_pkg::DEPTH_DEF,
  parameter int BLOCK_SIZE = bdrs_pkg::BLOCK_SIZE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bdrs_pkg::bdrs_cmd_t         cmd,
  output bdrs_pkg::bdrs_sts_t              sts,
  input  wire logic                        in_operation,
  input  wire logic [bdrs_pkg::IDX_W-1:0]  in_left_index,
  input  wire logic [bdrs_pkg::IDX_W-1:0]  in_right_index,
  input  wire logic [bdrs_pkg::DATA_W-1:0] in_value,
  output logic [bdrs_pkg::DATA_W-1:0]      sum
);
  import bdrs_pkg::*;

  localparam int NUM_BLOCKS = (DEPTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW         = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LBS        = $clog2(BLOCK_SIZE);
  localparam int CW         = WALK_W + AW + 1;

  logic [DATA_W-1:0] elem_mem [DEPTH];
  logic [DATA_W-1:0] bsum_mem [NUM_BLOCKS];

  logic [WALK_W-1:0] idx_r,   idx_nxt;
  logic [IDX_W-1:0]  hi_r,    hi_nxt;
  logic [DATA_W-1:0] val_r,   val_nxt;
  logic [DATA_W-1:0] acc_r,   acc_nxt;
  logic              pend_r,  pend_nxt;
  logic              sel_blk_r, sel_blk_nxt;
  logic              sel_zero_r, sel_zero_nxt;
  logic [AW-1:0]     clr_r,   clr_nxt;
  logic [DATA_W-1:0] elem_rd_r;
  logic [DATA_W-1:0] bsum_rd_r;

  logic [CW-1:0]     idx_ext;
  logic [CW-1:0]     clr_ext;
  logic              idx_in;
  logic              clr_in_nb;
  logic              blk_ok;
  logic              more;
  logic [AW-1:0]     elem_addr;
  logic [BW-1:0]     blk_addr;
  logic [DATA_W-1:0] add_val;
  logic              e_we;
  logic [AW-1:0]     e_waddr;
  logic [DATA_W-1:0] e_wdata;
  logic              b_we;
  logic [BW-1:0]     b_waddr;
  logic [DATA_W-1:0] b_wdata;

  assign idx_ext   = {{(CW-WALK_W){1'b0}}, idx_r};
  assign clr_ext   = {{(CW-AW){1'b0}}, clr_r};
  assign idx_in    = idx_ext < CW'(DEPTH);
  assign clr_in_nb = clr_ext < CW'(NUM_BLOCKS);
  assign elem_addr = idx_ext[AW-1:0];
  assign blk_addr  = idx_ext[LBS +: BW];
  assign more      = idx_r <= {1'b0, hi_r};

  // A whole block can be taken from its stored sum when the walk sits on a
  // block boundary and the block ends inside the range.
  assign blk_ok = idx_in && (idx_r[LBS-1:0] == '0) &&
                  (({1'b0, idx_r} + (WALK_W+1)'(BLOCK_SIZE - 1)) <= {2'b0, hi_r});

  assign add_val = sel_zero_r ? '0 : (sel_blk_r ? bsum_rd_r : elem_rd_r);

  always_comb begin
    idx_nxt      = idx_r;
    hi_nxt       = hi_r;
    val_nxt      = val_r;
    acc_nxt      = acc_r;
    pend_nxt     = pend_r;
    sel_blk_nxt  = sel_blk_r;
    sel_zero_nxt = sel_zero_r;
    clr_nxt      = clr_r;
    if (pend_r) begin
      acc_nxt = acc_r + add_val;
    end
    if (cmd.load) begin
      idx_nxt  = {1'b0, in_left_index};
      hi_nxt   = in_right_index;
      val_nxt  = in_value;
      acc_nxt  = '0;
      pend_nxt = 1'b0;
    end
    if (cmd.q_step) begin
      pend_nxt = more;
      if (more) begin
        sel_blk_nxt  = blk_ok;
        sel_zero_nxt = !idx_in;
        idx_nxt      = blk_ok ? (idx_r + WALK_W'(BLOCK_SIZE)) : (idx_r + 1'b1);
      end
    end
    if (cmd.clr_step) begin
      clr_nxt = clr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      clr_r  <= '0;
      acc_r  <= '0;
    end else begin
      pend_r <= pend_nxt;
      clr_r  <= clr_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    hi_r       <= hi_nxt;
    val_r      <= val_nxt;
    sel_blk_r  <= sel_blk_nxt;
    sel_zero_r <= sel_zero_nxt;
  end

  // Write ports: the clearing pass, or an update of one element and its block.
  always_comb begin
    e_we    = cmd.clr_step || (cmd.wr_upd && idx_in);
    e_waddr = cmd.clr_step ? clr_r : elem_addr;
    e_wdata = cmd.clr_step ? '0 : val_r;
    b_we    = (cmd.clr_step && clr_in_nb) || (cmd.wr_upd && idx_in);
    b_waddr = cmd.clr_step ? clr_ext[BW-1:0] : blk_addr;
    b_wdata = cmd.clr_step ? '0 : (bsum_rd_r + val_r - elem_rd_r);
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      elem_mem[e_waddr] <= e_wdata;
    end
    elem_rd_r <= elem_mem[elem_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      bsum_mem[b_waddr] <= b_wdata;
    end
    bsum_rd_r <= bsum_mem[blk_addr];
  end

  always_comb begin
    sts.clr_last = (clr_r == AW'(DEPTH - 1));
    sts.is_query = (in_operation == OP_QUERY);
    sts.more     = more;
  end

  assign sum = acc_r;

endmodule

`default_nettype wire

// ----- hdl/block_decomposed_range_sum.sv -----
`default_nettype none

// Range-sum store in square-root decomposition form. It holds DEPTH signed
// 32-bit elements and one running sum per group of BLOCK_SIZE elements
// (BLOCK_SIZE must be a power of two). A beat is accepted when start is
// high and busy is low. A write beat (operation 0) replaces the element at
// left_index and corrects its block sum; once accepted it reads the old
// element and block sum, then writes both, and produces no result. A
// write beyond DEPTH is dropped. A query beat (operation 1) returns the
// wrapped sum over left_index through right_index inclusive; an empty
// range returns zero and positions at or beyond DEPTH count as zero. The
// query walk reads one element or one block sum per cycle, S reads in all,
// where S is the number of partial-block elements at both ends plus the
// number of whole blocks covered. When the store spans the whole index
// range, S is at most 2*(BLOCK_SIZE-1) + DEPTH/BLOCK_SIZE - 2. The result
// appears on out_range_sum for exactly one cycle with out_valid high; the
// receiver cannot stall it, and the block stays busy until that cycle has
// passed. After reset both stores are cleared by a pass over every element,
// one element (and block sum) per cycle, during which busy stays high.

module block_decomposed_range_sum #(
  parameter int DEPTH      = bdrs_pkg::DEPTH_DEF,
  parameter int BLOCK_SIZE = bdrs_pkg::BLOCK_SIZE_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               in_operation,
  input  wire logic [bdrs_pkg::IDX_W-1:0]         in_left_index,
  input  wire logic [bdrs_pkg::IDX_W-1:0]         in_right_index,
  input  wire logic signed [bdrs_pkg::DATA_W-1:0] in_value,
  output logic                                    out_valid,
  output logic signed [bdrs_pkg::DATA_W-1:0]      out_range_sum
);
  import bdrs_pkg::*;

  bdrs_cmd_t         cmd;
  bdrs_sts_t         sts;
  logic [DATA_W-1:0] sum;

  // The controller sequences the clearing pass, writes and query walks.
  bdrs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath owns both stores, the walk index and the accumulator.
  bdrs_dp #(
    .DEPTH      (DEPTH),
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_operation   (in_operation),
    .in_left_index  (in_left_index),
    .in_right_index (in_right_index),
    .in_value       (in_value),
    .sum            (sum)
  );

  // The accumulator holds steady while the result beat is shown.
  assign out_range_sum = $signed(sum);

endmodule

`default_nettype wire

// ----- verif/tb_block_decomposed_range_sum.sv -----
module tb_block_decomposed_range_sum;
  import bdrs_pkg::*;

  // Geometry of the instance under test. It uses the package defaults, so
  // every index the 10-bit ports can carry lies inside the store.
  localparam int DEPTH      = DEPTH_DEF;
  localparam int BLOCK      = BLOCK_SIZE_DEF;
  localparam int NUM_BLOCKS = (DEPTH + BLOCK - 1) / BLOCK;

  localparam int N_DIRECTED   = 25;
  localparam int RANDOM_BEATS = 800;
  localparam int MAX_GAP      = 4;

  // The longest query walks two partial blocks and every whole block
  // between them.
  localparam int MAX_QUERY_CYCLES = 2 + 2 * (BLOCK - 1) + NUM_BLOCKS;

  // The slowest correct run is the clearing pass after reset followed by
  // every beat being a longest query behind a longest gap. The limit is
  // five times that.
  localparam int CYCLE_LIMIT =
    5 * (DEPTH + (N_DIRECTED + RANDOM_BEATS) * (MAX_QUERY_CYCLES + MAX_GAP + 2));

  // One row of the directed table. Where has_sum is set, the expected sum is
  // typed in; otherwise it comes from the predictor.
  typedef struct packed {
    logic                     op;
    logic [IDX_W-1:0]         left;
    logic [IDX_W-1:0]         right;
    logic signed [DATA_W-1:0] value;
    logic                     has_sum;
    logic signed [DATA_W-1:0] sum;
  } stim_row_t;

  // Fields that the operation ignores carry odd patterns, so that the block
  // is seen to ignore them.
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    // Right after reset the whole store reads as zero.
    '{OP_QUERY, 10'd0,    10'd1023, 32'h5A5A_A5A5, 1'b1, 32'sd0},
    // Empty range spanning the whole index space.
    '{OP_QUERY, 10'd1023, 10'd0,    32'hFFFF_FFFF, 1'b1, 32'sd0},
    // Largest and smallest values at both ends of the store.
    '{OP_WRITE, 10'd0,    10'd1023, 32'h7FFF_FFFF, 1'b0, 32'sd0},
    '{OP_WRITE, 10'd1023, 10'd0,    32'h8000_0000, 1'b0, 32'sd0},
    '{OP_QUERY, 10'd0,    10'd0,    32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
    '{OP_QUERY, 10'd1023, 10'd1023, 32'hA5A5_5A5A, 1'b1, 32'h8000_0000},
    '{OP_QUERY, 10'd0,    10'd1023, 32'h1234_5678, 1'b1, 32'hFFFF_FFFF},
    // Two largest values next to each other overflow and wrap.
    '{OP_WRITE, 10'd1,    10'd555,  32'h7FFF_FFFF, 1'b0, 32'sd0},
    '{OP_QUERY, 10'd0,    10'd1,    32'hFFFF_0000, 1'b1, 32'hFFFF_FFFE},
    // Values around the boundary between the first two blocks.
    '{OP_WRITE, 10'd31,   10'd2,    -32'sd5,       1'b0, 32'sd0},
    '{OP_WRITE, 10'd32,   10'd7,    32'sd1000,     1'b0, 32'sd0},
    '{OP_WRITE, 10'd63,   10'd9,    -32'sd1,       1'b0, 32'sd0},
    '{OP_QUERY, 10'd31,   10'd32,   32'h0F0F_0F0F, 1'b0, 32'sd0},
    '{OP_QUERY, 10'd32,   10'd63,   32'hF0F0_F0F0, 1'b0, 32'sd0},
    '{OP_QUERY, 10'd0,    10'd63,   32'h0000_0001, 1'b0, 32'sd0},
    // Overwrite: the old value has to leave the block sum.
    '{OP_WRITE, 10'd32,   10'd3,    32'h2AAA_AAAA, 1'b0, 32'sd0},
    '{OP_QUERY, 10'd1,    10'd1022, 32'h8000_0001, 1'b0, 32'sd0},
    // Alternating index and value bit patterns.
    '{OP_WRITE, 10'h2AA,  10'h155,  32'h5555_5555, 1'b0, 32'sd0},
    '{OP_WRITE, 10'h155,  10'h2AA,  32'hAAAA_AAAA, 1'b0, 32'sd0},
    '{OP_QUERY, 10'h155,  10'h2AA,  32'h3C3C_C3C3, 1'b0, 32'sd0},
    // Empty range with neighboring indexes.
    '{OP_QUERY, 10'd5,    10'd4,    32'h0000_0000, 1'b1, 32'sd0},
    // A range inside one block uses no block sum at all.
    '{OP_QUERY, 10'd33,   10'd62,   32'hC3C3_3C3C, 1'b0, 32'sd0},
    '{OP_QUERY, 10'd0,    10'd1023, 32'h7777_7777, 1'b0, 32'sd0},
    '{OP_WRITE, 10'd0,    10'd1023, 32'sd0,        1'b0, 32'sd0},
    '{OP_QUERY, 10'd0,    10'd31,   32'h8888_8888, 1'b0, 32'sd0}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_operation;
  logic [IDX_W-1:0]         in_left_index;
  logic [IDX_W-1:0]         in_right_index;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_range_sum;

  // Shadow copy of the store: the elements and one running sum per block.
  logic [DATA_W-1:0] elem_shadow  [DEPTH];
  logic [DATA_W-1:0] block_shadow [NUM_BLOCKS];

  // Sums that accepted queries are owed, oldest first.
  logic signed [DATA_W-1:0] pending_sums [$];

  int error_count = 0;
  int cycle_count = 0;

  block_decomposed_range_sum #(
    .DEPTH      (DEPTH),
    .BLOCK_SIZE (BLOCK)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_left_index  (in_left_index),
    .in_right_index (in_right_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_range_sum  (out_range_sum)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // A write replaces one element and moves its block sum by the difference,
  // all modulo 2^32. Writes past the end of the store are dropped.
  function automatic void apply_write(input int unsigned idx, input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] old_val;
    if (idx < DEPTH) begin
      old_val = elem_shadow[idx];
      elem_shadow[idx] = val;
      block_shadow[idx / BLOCK] += val - old_val;
    end
  endfunction

  // Walks the range the way the block does: a block that starts at the walk
  // position and ends inside the range is taken from its running sum, and
  // everything else is added element by element. Positions past the end of
  // the store add nothing, and an empty range sums to zero.
  function automatic logic [DATA_W-1:0] predict_range_sum(input int unsigned lo,
                                                          input int unsigned hi);
    logic [DATA_W-1:0] acc;
    int unsigned       pos;
    acc = '0;
    pos = lo;
    while (pos <= hi) begin
      if (pos < DEPTH && pos % BLOCK == 0 && pos + BLOCK - 1 <= hi) begin
        acc += block_shadow[pos / BLOCK];
        pos += BLOCK;
      end else begin
        if (pos < DEPTH) begin
          acc += elem_shadow[pos];
        end
        pos++;
      end
    end
    return acc;
  endfunction

  // Keeps start low for the given number of cycles. Each falling edge gets
  // exactly one assignment to start.
  task automatic idle_cycles(input int n);
    repeat (n) @(negedge clk) start <= 1'b0;
  endtask

  // Presents one beat at the falling edge and holds it until a rising edge
  // finds busy low. The shadow store and the owed sums are updated at that
  // accepting edge. A typed-in sum, where given, stands in for the predictor.
  task automatic issue_beat(input logic                     op,
                            input logic [IDX_W-1:0]         lo,
                            input logic [IDX_W-1:0]         hi,
                            input logic signed [DATA_W-1:0] val,
                            input logic                     has_sum,
                            input logic signed [DATA_W-1:0] sum);
    @(negedge clk);
    start          <= 1'b1;
    in_operation   <= op;
    in_left_index  <= lo;
    in_right_index <= hi;
    in_value       <= val;
    // Outputs are read right after the rising edge, before the block's own
    // updates of that edge land, so this sees the value the edge acted on.
    do @(posedge clk); while (busy !== 1'b0);
    if (op == OP_WRITE) begin
      apply_write(32'(lo), val);
    end else begin
      pending_sums.push_back(has_sum ? sum : predict_range_sum(32'(lo), 32'(hi)));
    end
  endtask

  // Result checker. The receiver cannot hold results off, so every cycle
  // with out_valid high is a result beat that must match the oldest owed sum.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_sums.size() == 0) begin
        $error("out_range_sum: unexpected result beat, got %0d", out_range_sum);
        error_count++;
      end else if (out_range_sum !== pending_sums[0]) begin
        $error("out_range_sum mismatch: expected %0d, got %0d",
               pending_sums[0], out_range_sum);
        error_count++;
        void'(pending_sums.pop_front());
      end else begin
        void'(pending_sums.pop_front());
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL block_decomposed_range_sum");
      $finish;
    end
  end

  initial begin
    logic                     op;
    int                       lo;
    int                       hi;
    int                       a;
    int                       b;
    logic signed [DATA_W-1:0] val;
    int                       burst_left;
    int                       gap;

    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = OP_WRITE;
    in_left_index  = '0;
    in_right_index = '0;
    in_value       = '0;
    burst_left     = 0;
    foreach (elem_shadow[i]) elem_shadow[i] = '0;
    foreach (block_shadow[i]) block_shadow[i] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // The block runs its clearing pass right after reset with busy high, so
    // the first beat simply waits in the handshake until that is over.
    for (int r = 0; r < N_DIRECTED; r++) begin
      idle_cycles($urandom_range(0, MAX_GAP));
      issue_beat(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].left, DIRECTED_ROWS[r].right,
                 DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].has_sum, DIRECTED_ROWS[r].sum);
    end

    // Random part. Fields that an operation ignores are always random. Query
    // ranges come in several shapes so that the walk covers empty ranges,
    // the full store, runs of whole blocks, short spans across a boundary
    // and arbitrary spans. Writes lean toward block edges and extreme values.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      op  = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_QUERY;
      val = $urandom;
      hi  = $urandom_range(0, DEPTH - 1);
      if (op == OP_WRITE) begin
        if ($urandom_range(0, 3) == 0) begin
          lo = $urandom_range(0, NUM_BLOCKS - 1) * BLOCK +
               ($urandom_range(0, 1) ? BLOCK - 1 : 0);
        end else begin
          lo = $urandom_range(0, DEPTH - 1);
        end
        if ($urandom_range(0, 4) == 0) begin
          case ($urandom_range(0, 3))
            0: val = 32'h7FFF_FFFF;
            1: val = 32'h8000_0000;
            2: val = 32'hFFFF_FFFF;
            default: val = 32'h0000_0000;
          endcase
        end
      end else begin
        case ($urandom_range(0, 9))
          0: begin
            lo = $urandom_range(1, DEPTH - 1);
            hi = $urandom_range(0, lo - 1);
          end
          1: begin
            lo = 0;
            hi = DEPTH - 1;
          end
          2: begin
            a  = $urandom_range(0, NUM_BLOCKS - 1);
            b  = $urandom_range(a, NUM_BLOCKS - 1);
            lo = a * BLOCK;
            hi = b * BLOCK + BLOCK - 1;
          end
          3, 4, 5: begin
            lo = $urandom_range(0, DEPTH - 1);
            hi = lo + $urandom_range(0, 2 * BLOCK + 6);
            if (hi > DEPTH - 1) hi = DEPTH - 1;
          end
          default: begin
            a  = $urandom_range(0, DEPTH - 1);
            b  = $urandom_range(0, DEPTH - 1);
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
          end
        endcase
      end

      // Random idle gaps between beats, broken now and then by a stretch of
      // back-to-back beats.
      if (burst_left == 0 && $urandom_range(0, 15) == 0) begin
        burst_left = $urandom_range(10, 30);
      end
      if (burst_left > 0) begin
        gap = 0;
        burst_left--;
      end else begin
        gap = $urandom_range(0, MAX_GAP);
      end
      idle_cycles(gap);
      issue_beat(op, lo[IDX_W-1:0], hi[IDX_W-1:0], val, 1'b0, '0);
    end

    @(negedge clk) start <= 1'b0;

    // Drain the owed sums, then give the block a full query time to show
    // any stray result beat.
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (MAX_QUERY_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS block_decomposed_range_sum");
    end else begin
      $display("FAIL block_decomposed_range_sum");
    end
    $finish;
  end

endmodule
